// ===== sv/pcs_pkg.sv =====
`default_nettype none
package pcs_pkg;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } pcs_op_t;

  typedef struct packed {
    logic    start;
    pcs_op_t op;
  } pcs_req_t;

  typedef struct packed {
    logic         lost;
    logic [127:0] m;
  } pcs_shl_t;

  // configuration register indexes
  localparam logic [2:0] REG_MAX_FREQ   = 3'd0;
  localparam logic [2:0] REG_MAX_OFFSET = 3'd1;
  localparam logic [2:0] REG_MAX_JUMP   = 3'd2;
  localparam logic [2:0] REG_FREQ_WT    = 3'd3;
  localparam logic [2:0] REG_PHASE_WT   = 3'd4;
  localparam logic [2:0] REG_COMP_WT    = 3'd5;
  localparam logic [2:0] REG_COMP_MAX   = 3'd6;
  localparam logic [2:0] REG_COMP_MULT  = 3'd7;

  // servo states
  localparam logic [1:0] LOCK_UNLOCKED = 2'd0;
  localparam logic [1:0] LOCK_JUMP     = 2'd1;
  localparam logic [1:0] LOCK_LOCKED   = 2'd2;
  localparam logic [1:0] LOCK_STALE    = 2'd3;

  localparam logic [63:0] NS_PER_S   = 64'd1000000000;
  localparam logic [63:0] WAIT_NS    = 64'd15984015985;  // 1.001 * diff >= 16 s
  localparam logic [29:0] FREQ_LIMIT = 30'd900000000;

  // floor(2^93 / 1e9): (x * RECIP_NS) >> RECIP_SH is x / 1e9 or one less
  localparam logic [63:0] RECIP_NS = 64'd9903520314283042199;
  localparam int          RECIP_SH = 93;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] tosat(input logic [127:0] m, input logic neg);
    if (neg) begin
      if (|m[127:63]) return S64_MIN;
      return -signed'(m[63:0]);
    end
    if (|m[127:63]) return S64_MAX;
    return signed'(m[63:0]);
  endfunction

  function automatic pcs_shl_t shl(input logic [63:0] a, input logic [6:0] s);
    logic [191:0] ext;
    pcs_shl_t     r;
    ext    = {128'd0, a} << s;
    r.lost = |ext[191:128];
    r.m    = ext[127:0];
    return r;
  endfunction

  function automatic logic signed [63:0] scale(input logic signed [63:0] a,
                                               input logic [6:0] s);
    pcs_shl_t r;
    r = shl(mag(a), s);
    if (r.lost) return a[63] ? S64_MIN : S64_MAX;
    return tosat(r.m, a[63]);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/pcs_muldiv.sv =====
`default_nettype none
// Bit-serial unsigned unit: 64x64 shift-add multiply or
// 128/64 restoring divide. One 66-bit adder serves both.
module pcs_muldiv import pcs_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  pcs_req_t       req,
  input  logic [127:0]   a,       // mul: multiplier in [63:0]; div: dividend
  input  logic [63:0]    b,       // mul: multiplicand; div: divisor (< 2^63)
  output logic           done,
  output logic [127:0]   result
);

  logic          busy;
  pcs_op_t       op_r;
  logic [63:0]   hi;
  logic [127:0]  work;
  logic [63:0]   opnd;
  logic [6:0]    cnt;

  logic          sub;
  logic [64:0]   x;
  logic [64:0]   y;
  logic [65:0]   s;
  logic          ge;

  always_comb begin
    sub = (op_r == OP_DIV);
    x   = sub ? {hi, work[127]} : {1'b0, hi};
    y   = (sub || work[0]) ? {1'b0, opnd} : 65'd0;
    s   = {1'b0, x} + (sub ? ~{1'b0, y} : {1'b0, y}) + 66'(sub);
    ge  = !s[65];
    result = sub ? work : {hi, work[63:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_r <= req.op;
        hi   <= '0;
        work <= a;
        opnd <= b;
        cnt  <= (req.op == OP_DIV) ? 7'd127 : 7'd63;
      end else if (busy) begin
        if (sub) begin
          hi   <= ge ? s[63:0] : x[63:0];
          work <= {work[126:0], ge};
        end else begin
          hi         <= s[64:1];
          work[63:0] <= {s[0], work[63:1]};
        end
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptp_pll_clock_servo_core.sv =====
`default_nettype none
// Channel  Dir  Handshake               Payload
// in       in   in_valid / in_ready     offset_ns, local_time_ns
// out      out  out_valid / out_ready   adjust_ppb, lock_state
// cfg      in   cfg_we                  cfg_index, cfg_data
//
// One item at a time. First, waiting, lock-decision, offset-reset and stale
// samples go from ST_DECIDE straight to ST_DONE. A run-phase item takes
// two multiplies for the whole seconds (reciprocal estimate, then a check),
// two more multiplies and three divides on the shared bit-serial unit, plus
// saturating adds.
// rst is synchronous; it clears the servo state and loads register defaults.
// A result held by out_ready low stalls the sequencer before its output load.
module ptp_pll_clock_servo_core import pcs_pkg::*; #(
  parameter int FRAC_BITS   = 32,
  parameter int OFFSET_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [OFFSET_BITS-1:0] offset_ns,
  input  logic [63:0]                   local_time_ns,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [46:0]            adjust_ppb,
  output logic [1:0]                    lock_state,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [46:0]                   cfg_data
);

  localparam logic signed [63:0] ONE_Q    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] POINT3_Q = ((64'sd3 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
  localparam logic signed [63:0] COMP_RST = 64'sd1 <<< (4 + FRAC_BITS);
  localparam logic [6:0]         FRAC_SH  = 7'(FRAC_BITS);
  localparam logic [6:0]         FRAC2_SH = 7'(2 * FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_SECS, ST_REM, ST_M1, ST_Q1, ST_X, ST_PE, ST_TC, ST_M2,
    ST_CMP1, ST_CMP2, ST_CO, ST_OUT, ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic [29:0] max_freq_ppb;
  logic [46:0] max_offset_ns;
  logic [46:0] max_jump_offset_ns;
  logic [5:0]  freq_weight_exp;
  logic [5:0]  phase_weight_exp;
  logic [5:0]  compliance_weight_exp;
  logic [4:0]  compliance_max_exp;
  logic [4:0]  compliance_mult_exp;

  // servo state
  logic [1:0]         phase_count;
  logic               first_pass;
  logic [63:0]        first_time;
  logic [63:0]        last_time;
  logic signed [63:0] freq_error;
  logic signed [63:0] time_constant;
  logic signed [63:0] compliance;
  logic signed [63:0] control_output;

  // per-item working registers
  logic signed [63:0] off_r;
  logic [63:0]        t_r;
  logic [63:0]        span_ns;
  logic [63:0]        secs_r;
  logic               div_sat;
  logic               div_neg;
  logic signed [63:0] pe_r;
  logic signed [63:0] tmp_r;
  logic signed [46:0] adj_r;
  logic [1:0]         st_r;

  // shared unit
  pcs_req_t     md_req;
  logic [127:0] md_a;
  logic [63:0]  md_b;
  logic         md_done;
  logic [127:0] md_result;

  pcs_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .a      (md_a),
    .b      (md_b),
    .done   (md_done),
    .result (md_result)
  );

  // output scale: Q(FRAC) to 16 fraction bits, floor, then clamp
  function automatic logic signed [46:0] clamp_out(input logic signed [63:0] q,
                                                   input logic [29:0] mf_in);
    logic [29:0]        mf;
    logic signed [63:0] lim;
    logic signed [63:0] v;
    mf  = (mf_in > FREQ_LIMIT) ? FREQ_LIMIT : mf_in;
    lim = signed'(64'(mf) << 16);
    v   = q >>> (FRAC_BITS - 16);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[46:0];
  endfunction

  logic [63:0]           omag;
  logic                  off_neg;
  logic                  over_offset;
  logic                  over_jump;
  logic [63:0]           t_diff;
  logic [127-RECIP_SH:0] secs_est;
  logic [63:0]           rem_ns;
  logic [63:0]           secs;
  logic signed [63:0]    ui;
  logic signed [63:0]    prod_sat;
  logic signed [63:0]    div_val;
  logic signed [63:0]    sh_src;
  logic [6:0]            sh_amt;
  pcs_shl_t              sh;
  logic signed [63:0]    tcv;
  logic signed [63:0]    tc_new;

  always_comb begin
    omag        = mag(off_r);
    off_neg     = off_r[63];
    over_offset = (max_offset_ns != '0) && (64'(max_offset_ns) < omag);
    over_jump   = (max_jump_offset_ns != '0) && (64'(max_jump_offset_ns) < omag);
    t_diff      = t_r - last_time;
    // whole seconds: reciprocal estimate, bumped by one when the remainder
    // is still a full second
    secs_est    = md_result[127:RECIP_SH];
    rem_ns      = span_ns - md_result[63:0];
    secs        = (rem_ns >= NS_PER_S) ? secs_r + 64'd1 : secs_r;
    // update interval: whole seconds, 0.3 s when under one second
    ui          = (secs == '0) ? POINT3_Q : scale(signed'(secs), FRAC_SH);
    prod_sat    = tosat(md_result, off_neg);
    div_val     = div_sat ? (div_neg ? S64_MIN : S64_MAX) : tosat(md_result, div_neg);
    tcv         = sat_sub(scale(64'sd1, 7'(compliance_max_exp) + FRAC_SH), compliance);
    tc_new      = (tcv > ONE_Q) ? tcv : ONE_Q;

    // dividend prep for the three Q divides
    case (state)
      ST_M1:   begin sh_src = prod_sat; sh_amt = FRAC_SH;  end
      ST_Q1:   begin sh_src = div_val;  sh_amt = FRAC_SH;  end
      default: begin sh_src = off_r;    sh_amt = FRAC2_SH; end
    endcase
    sh = shl(mag(sh_src), sh_amt);

    md_req.start = 1'b0;
    md_req.op    = OP_DIV;
    md_a         = {64'd0, t_diff};
    md_b         = NS_PER_S;
    case (state)
      ST_DECIDE: begin
        md_req.start = (phase_count[1] && !over_offset && (t_r > last_time));
        md_req.op    = OP_MUL;
        md_b         = RECIP_NS;
      end
      ST_SECS: begin
        md_req.start = md_done;
        md_req.op    = OP_MUL;
        md_a         = 128'(secs_est);
        md_b         = NS_PER_S;
      end
      ST_REM: begin
        md_req.start = md_done;
        md_req.op    = OP_MUL;
        md_a         = {64'd0, mag(ui)};
        md_b         = omag;
      end
      ST_M1, ST_Q1, ST_X: begin
        md_req.start = md_done;
        md_a         = sh.m;
        md_b         = 64'(time_constant);
      end
      ST_TC: begin
        md_req.start = 1'b1;
        md_req.op    = OP_MUL;
        md_a         = {64'd0, mag(tc_new)};
        md_b         = omag;
      end
      default: ;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= ST_IDLE;
      out_valid             <= 1'b0;
      max_freq_ppb          <= FREQ_LIMIT;
      max_offset_ns         <= '0;
      max_jump_offset_ns    <= 47'd100;
      freq_weight_exp       <= 6'd24;
      phase_weight_exp      <= 6'd10;
      compliance_weight_exp <= 6'd13;
      compliance_max_exp    <= 5'd4;
      compliance_mult_exp   <= 5'd14;
      phase_count           <= 2'd0;
      first_pass            <= 1'b1;
      first_time            <= '0;
      last_time             <= '0;
      freq_error            <= '0;
      time_constant         <= ONE_Q;
      compliance            <= COMP_RST;
      control_output        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_FREQ:   max_freq_ppb          <= cfg_data[29:0];
          REG_MAX_OFFSET: max_offset_ns         <= cfg_data;
          REG_MAX_JUMP:   max_jump_offset_ns    <= cfg_data;
          REG_FREQ_WT:    freq_weight_exp       <= cfg_data[5:0];
          REG_PHASE_WT:   phase_weight_exp      <= cfg_data[5:0];
          REG_COMP_WT:    compliance_weight_exp <= cfg_data[5:0];
          REG_COMP_MAX:   compliance_max_exp    <= cfg_data[4:0];
          REG_COMP_MULT:  compliance_mult_exp   <= cfg_data[4:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            off_r <= 64'(offset_ns);
            t_r   <= local_time_ns;
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          adj_r <= '0;
          st_r  <= LOCK_UNLOCKED;
          state <= ST_DONE;
          case (phase_count)
            2'd0: begin
              first_time  <= t_r;
              phase_count <= 2'd1;
            end
            2'd1: begin
              last_time <= t_r;
              if (first_time >= t_r) begin
                // out-of-order sample: restart
                phase_count <= 2'd0;
              end else if (t_r - first_time >= WAIT_NS) begin
                if (!first_pass || over_jump || over_offset) begin
                  st_r      <= LOCK_JUMP;
                  last_time <= t_r - off_r;
                end else begin
                  st_r <= LOCK_LOCKED;
                end
                first_pass  <= 1'b0;
                adj_r       <= clamp_out(freq_error, max_freq_ppb);
                phase_count <= 2'd2;
              end
            end
            default: begin
              if (over_offset) begin
                phase_count <= 2'd0;
              end else if (t_r <= last_time) begin
                st_r <= LOCK_STALE;
              end else begin
                span_ns   <= t_diff;
                last_time <= t_r;
                state     <= ST_SECS;
              end
            end
          endcase
        end
        ST_SECS: begin
          if (md_done) begin
            secs_r <= 64'(secs_est);
            state  <= ST_REM;
          end
        end
        ST_REM: if (md_done) state <= ST_M1;
        ST_M1: begin
          if (md_done) begin
            div_sat <= sh.lost;
            div_neg <= prod_sat[63];
            state   <= ST_Q1;
          end
        end
        ST_Q1: begin
          if (md_done) begin
            div_sat <= sh.lost;
            div_neg <= div_val[63];
            state   <= ST_X;
          end
        end
        ST_X: begin
          if (md_done) begin
            freq_error <= sat_add(freq_error, div_val);
            div_sat    <= sh.lost;
            div_neg    <= off_neg;
            state      <= ST_PE;
          end
        end
        ST_PE: begin
          if (md_done) begin
            pe_r  <= div_val;
            state <= ST_TC;
          end
        end
        ST_TC: begin
          time_constant <= tc_new;
          state         <= ST_M2;
        end
        ST_M2: begin
          if (md_done) begin
            tmp_r <= scale(prod_sat, 7'(compliance_mult_exp));
            state <= ST_CMP1;
          end
        end
        ST_CMP1: begin
          tmp_r <= sat_sub(tmp_r, compliance) >>> compliance_weight_exp;
          state <= ST_CMP2;
        end
        ST_CMP2: begin
          compliance <= sat_add(compliance, tmp_r);
          tmp_r      <= sat_add(pe_r >>> phase_weight_exp, freq_error >>> freq_weight_exp);
          state      <= ST_CO;
        end
        ST_CO: begin
          control_output <= sat_add(control_output, tmp_r);
          state          <= ST_OUT;
        end
        ST_OUT: begin
          adj_r <= clamp_out(control_output, max_freq_ppb);
          st_r  <= LOCK_LOCKED;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            adjust_ppb <= adj_r;
            lock_state <= st_r;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/pcs_checker.sv =====
`default_nettype none
module pcs_checker import pcs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [46:0] adjust_ppb,
  input logic [1:0]         lock_state
);

  // one item in flight: no accept on the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while item in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(adjust_ppb) && $stable(lock_state))
    else $error("stalled result changed");

  // unlocked and stale answers carry no adjustment
  a_zero_adj: assert property (@(posedge clk) disable iff (rst)
    out_valid && (lock_state == LOCK_UNLOCKED || lock_state == LOCK_STALE)
      |-> adjust_ppb == '0)
    else $error("nonzero adjustment on unlocked or stale result");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ptp_pll_clock_servo_core pcs_checker u_pcs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .adjust_ppb (adjust_ppb),
  .lock_state (lock_state)
);
`default_nettype wire

// ===== dv/ptp_pll_clock_servo_core_tb.sv =====
`default_nettype none
module ptp_pll_clock_servo_core_tb;
  import pcs_pkg::*;

  typedef logic signed [63:0] q_t;

  localparam int   FRAC   = 32;
  localparam q_t   Q_MAX  = {1'b0, {63{1'b1}}};
  localparam q_t   Q_MIN  = {1'b1, {63{1'b0}}};
  localparam q_t   Q_ONE  = q_t'(64'd1 << FRAC);
  localparam q_t   Q_0P3  = q_t'(((64'd3 << FRAC) + 64'd5) / 64'd10);
  localparam int   DRAIN_CYCLES = 800;
  localparam int   HOLD_CYCLES  = 4000;

  typedef struct packed {
    logic signed [47:0] offset;
    logic [63:0]        ltime;
  } sample_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  // block ports
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [47:0] offset_ns = '0;
  logic [63:0]        local_time_ns = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [46:0] adjust_ppb;
  logic [1:0]         lock_state;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [46:0]        cfg_data = '0;

  ptp_pll_clock_servo_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .offset_ns(offset_ns), .local_time_ns(local_time_ns),
    .out_valid(out_valid), .out_ready(out_ready),
    .adjust_ppb(adjust_ppb), .lock_state(lock_state),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // pending samples and expected servo results
  sample_t            sample_q[$];
  logic signed [46:0] adj_exp_q[$];
  logic [1:0]         state_exp_q[$];

  int errors = 0;
  int n_items = 0, n_results = 0;
  int n_locked = 0, n_jump = 0, n_stale = 0, n_unlocked = 0;

  // idle percentages, set by the sequencer
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_epoch = 0;
  int seen_epoch = 0;
  int hold_cnt = 0;

  // predictor configuration (register reset values)
  logic [29:0]  pr_max_freq = 30'd900000000;
  logic [46:0]  pr_max_off  = 47'd0;
  logic [46:0]  pr_max_jump = 47'd100;
  int unsigned  pr_fwt = 24, pr_pwt = 10, pr_cwt = 13, pr_cmax = 4, pr_cmult = 14;

  // predictor servo state; compliance starts at 2^4 in Q32
  logic [1:0]   pr_phase = 2'd0;
  logic         pr_first = 1'b1;
  logic [63:0]  pr_t_first = '0, pr_t_last = '0;
  q_t           pr_freq = '0, pr_tconst = Q_ONE, pr_ctrl = '0;
  q_t           pr_compl = q_t'(64'd1 << (FRAC + 4));

  // ---------------- fixed-point helpers ----------------
  function automatic logic [63:0] abs64(q_t a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic q_t sat_mag(logic [127:0] m, logic neg);
    if (neg) return (m >= 128'h8000_0000_0000_0000) ? Q_MIN : q_t'(~m[63:0] + 64'd1);
    return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? Q_MAX : q_t'(m[63:0]);
  endfunction

  function automatic q_t q_scale(q_t a, int unsigned s);
    logic [191:0] w;
    w = {128'd0, abs64(a)} << s;
    if (|w[191:128]) return a[63] ? Q_MIN : Q_MAX;
    return sat_mag(w[127:0], a[63]);
  endfunction

  function automatic q_t q_mul(q_t a, q_t b, int unsigned s);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    return sat_mag(p >> s, a[63] ^ b[63]);
  endfunction

  function automatic q_t q_div(q_t a, q_t b, int unsigned s);
    logic [191:0] w;
    if (b <= 0) return a[63] ? Q_MIN : Q_MAX;
    w = {128'd0, abs64(a)} << s;
    if (|w[191:128]) return a[63] ? Q_MIN : Q_MAX;
    return sat_mag(w[127:0] / {64'd0, b}, a[63]);
  endfunction

  function automatic q_t q_add(q_t a, q_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  function automatic q_t q_sub(q_t a, q_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  function automatic q_t q_asr(q_t a, int unsigned n);
    return a >>> ((n > 63) ? 63 : n);
  endfunction

  // Q32 -> ppb with 16 fraction bits, clamped to the frequency limit
  function automatic logic [46:0] to_ppb(q_t a);
    logic [63:0] mf;
    q_t lim, v;
    mf  = (pr_max_freq > 30'd900000000) ? 64'd900000000 : {34'd0, pr_max_freq};
    lim = q_t'(mf << 16);
    v   = a >>> (FRAC - 16);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[46:0];
  endfunction

  // one sample through the servo; queues the expected result
  task automatic servo_predict(sample_t s);
    q_t          off, ui, pe, tc, x;
    logic [63:0] ou, omag, secs, t;
    logic [46:0] adj;
    logic [1:0]  st;
    off  = q_t'({{16{s.offset[47]}}, s.offset});
    ou   = off;
    omag = abs64(off);
    t    = s.ltime;
    adj  = '0;
    st   = LOCK_UNLOCKED;
    if (pr_phase == 2'd0) begin
      pr_t_first = t;
      pr_phase = 2'd1;
    end else if (pr_phase == 2'd1) begin
      pr_t_last = t;
      if (pr_t_first >= t) begin
        pr_phase = 2'd0;      // out-of-order first sample
      end else if (t - pr_t_first >= 64'd15984015985) begin
        if (!pr_first || (pr_max_jump != 0 && pr_max_jump < omag) ||
            (pr_max_off != 0 && pr_max_off < omag)) begin
          st = LOCK_JUMP;
          pr_t_last = t - ou;
        end else begin
          st = LOCK_LOCKED;
        end
        pr_first = 1'b0;
        adj = to_ppb(pr_freq);
        pr_phase = 2'd2;
      end
    end else begin
      if (pr_max_off != 0 && pr_max_off < omag) begin
        pr_phase = 2'd0;
      end else if (t <= pr_t_last) begin
        st = LOCK_STALE;
      end else begin
        secs = (t - pr_t_last) / 64'd1000000000;
        ui = (secs == 0) ? Q_0P3 : q_scale(q_t'(secs), FRAC);
        pr_t_last = t;
        x = q_div(q_div(q_mul(ui, off, 0), pr_tconst, FRAC), pr_tconst, FRAC);
        pr_freq = q_add(pr_freq, x);
        pe = q_div(off, pr_tconst, 2 * FRAC);
        tc = q_sub(q_scale(64'sd1, pr_cmax + FRAC), pr_compl);
        pr_tconst = (tc > Q_ONE) ? tc : Q_ONE;
        x = q_scale(q_mul(pr_tconst, off, 0), pr_cmult);
        pr_compl = q_add(pr_compl, q_asr(q_sub(x, pr_compl), pr_cwt));
        pr_ctrl = q_add(pr_ctrl, q_add(q_asr(pe, pr_pwt), q_asr(pr_freq, pr_fwt)));
        adj = to_ppb(pr_ctrl);
        st = LOCK_LOCKED;
      end
    end
    case (st)
      LOCK_LOCKED: n_locked++;
      LOCK_JUMP:   n_jump++;
      LOCK_STALE:  n_stale++;
      default:     n_unlocked++;
    endcase
    adj_exp_q.push_back(adj);
    state_exp_q.push_back(st);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        n_items++;
        servo_predict('{offset: offset_ns, ltime: local_time_ns});
      end
      // slot is free after this edge: offer the next item or idle
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          sample_t s;
          s = sample_q.pop_front();
          in_valid      <= 1'b1;
          offset_ns     <= s.offset;
          local_time_ns <= s.ltime;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor / receiver ----------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (adj_exp_q.size() == 0) begin
          report_mismatch("unexpected result", 64'({adjust_ppb, lock_state}), '0);
        end else begin
          logic signed [46:0] ea;
          logic [1:0]         es;
          ea = adj_exp_q.pop_front();
          es = state_exp_q.pop_front();
          if (adjust_ppb !== ea) report_mismatch("adjust_ppb", 64'(adjust_ppb), 64'(ea));
          if (lock_state !== es) report_mismatch("lock_state", 64'(lock_state), 64'(es));
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_epoch != seen_epoch) begin
        seen_epoch <= hold_epoch;
        hold_cnt   <= HOLD_CYCLES;
        out_ready  <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------- sequencer ----------------
  logic [63:0] t_cur = 64'd1000;

  function automatic logic [63:0] rand_bits(int w);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r >> (64 - $urandom_range(1, w));
  endfunction

  task automatic wait_drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || adj_exp_q.size() != 0);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [46:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MAX_FREQ:   pr_max_freq = data[29:0];
      REG_MAX_OFFSET: pr_max_off  = data;
      REG_MAX_JUMP:   pr_max_jump = data;
      REG_FREQ_WT:    pr_fwt   = data[5:0];
      REG_PHASE_WT:   pr_pwt   = data[5:0];
      REG_COMP_WT:    pr_cwt   = data[5:0];
      REG_COMP_MAX:   pr_cmax  = data[4:0];
      default:        pr_cmult = data[4:0];
    endcase
  endtask

  // writes all eight registers, then returns the port to idle
  task automatic cfg_all(logic [29:0] mf, logic [46:0] mo, logic [46:0] mj,
                         int fw, int pw, int cw, int cm, int cx);
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(REG_MAX_FREQ, 47'(mf));
    cfg_write(REG_MAX_OFFSET, mo);
    cfg_write(REG_MAX_JUMP, mj);
    cfg_write(REG_FREQ_WT, 47'(fw));
    cfg_write(REG_PHASE_WT, 47'(pw));
    cfg_write(REG_COMP_WT, 47'(cw));
    cfg_write(REG_COMP_MAX, 47'(cm));
    cfg_write(REG_COMP_MULT, 47'(cx));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push(logic signed [47:0] off, logic [63:0] t);
    sample_q.push_back('{offset: off, ltime: t});
  endtask

  // random sample; mostly a well-behaved sync stream, some noise
  task automatic push_random();
    int k;
    logic signed [47:0] off;
    k = $urandom_range(99);
    off = $signed(48'($urandom_range(2000))) - 48'sd1000;
    if (k < 70) begin
      t_cur += 64'($urandom_range(3000, 100)) * 64'd1000000;
    end else if (k < 78) begin
      t_cur += 64'($urandom_range(3000, 100)) * 64'd1000000;
      off = $signed(48'(rand_bits(48)));
    end else if (k < 84) begin
      t_cur -= 64'($urandom_range(2)) * 64'd1000000000;   // stale or out of order
    end else if (k < 88) begin
      t_cur = {$urandom, $urandom};
      off = $signed(48'({$urandom, $urandom} >> 16));
    end else if (k < 94) begin
      t_cur += 64'($urandom_range(60)) * 64'd1000000000 + 64'($urandom);
      off = $signed(48'($urandom_range(1 << 30))) - 48'sd536870912;
    end else begin
      t_cur += 64'($urandom_range(2000)) * 64'd1000000;
      case ($urandom_range(3))
        0:       off = {1'b0, {47{1'b1}}};
        1:       off = {1'b1, {47{1'b0}}};
        2:       off = -48'sd1;
        default: off = '0;
      endcase
    end
    push(off, t_cur);
  endtask

  initial begin
    logic [63:0] tb;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: default weights, offset limit 5000
    tx_idle_pct = 12; rx_idle_pct = 68;
    cfg_all(30'd900000000, 47'd5000, 47'd100, 24, 10, 13, 4, 14);
    push(48'sd0, 64'd0);                          // first sample
    push(48'sd0, 64'd0);                          // out-of-order restart
    push(48'sd1, 64'd100);                        // first sample
    push(-48'sd1, 64'd100 + 64'd15984015984);     // one ns short of the wait
    push(48'sd50, 64'd100 + 64'd15984015985);     // lock on first pass
    tb = 64'd100 + 64'd15984015985;
    push(48'sd7, tb + 64'd2000000000);            // run, two seconds
    push(48'sd7, tb + 64'd2000000000);            // stale
    push(-48'sd7, tb + 64'd2500000000);           // sub-second interval
    push(48'sd5000, tb + 64'd3500000000);         // at the offset limit
    push(-48'sd5000, tb + 64'd4500000000);
    push(48'sd5001, tb + 64'd5500000000);         // beyond limit: restart
    push({1'b0, {47{1'b1}}}, 64'h8000_0000_0000_0000);
    push({1'b1, {47{1'b0}}}, 64'h8000_0000_0000_0000 + 64'd15984015985); // jump
    push(48'sd0, 64'hFFFF_FFFF_FFFF_FFFF);
    push(48'sd3, 64'hFFFF_FFFF_FFFF_FFFF);        // stale at the top of time
    push(48'sd0, 64'h0);
    push(48'sd0, 64'd20000000000);
    push(48'sd200, 64'd40000000000);              // large offset, but stale: time below the last
    push(-48'sd1, 64'd41000000000);
    t_cur = 64'd41000000000;

    // defaults with limits disabled
    cfg_all(30'd900000000, 47'd0, 47'd0, 24, 10, 13, 4, 14);
    repeat (300) push_random();

    // low extremes of the weights, widest limits
    tx_idle_pct = 68; rx_idle_pct = 12;
    cfg_all({30{1'b1}}, {47{1'b1}}, {47{1'b1}}, 0, 0, 0, 0, 0);
    repeat (300) push_random();

    // high extremes; receiver holds off long while the sender keeps offering
    cfg_all(30'd0, 47'd1, 47'd1, 63, 63, 63, 31, 31);
    @(negedge clk);
    hold_epoch++;
    repeat (150) push_random();
    wait_drain();                                 // sender pauses until all results are back
    repeat (150) push_random();

    // random settings, no idling
    tx_idle_pct = 0; rx_idle_pct = 0;
    repeat (2) begin
      cfg_all(30'(rand_bits(30)), 47'(rand_bits(47)), 47'(rand_bits(47)),
              $urandom_range(63), $urandom_range(63), $urandom_range(63),
              $urandom_range(31), $urandom_range(31));
      repeat (250) push_random();
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("samples %0d, results %0d: locked %0d, jump %0d, stale %0d, unlocked %0d",
             n_items, n_results, n_locked, n_jump, n_stale, n_unlocked);
    $display("six register settings incl. weight and limit extremes, long output stall");
    if (errors == 0) begin
      $display("PASS ptp_pll_clock_servo_core");
    end else begin
      $display("FAIL ptp_pll_clock_servo_core");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20 * 8000000);
    $display("FAIL ptp_pll_clock_servo_core");
    $finish;
  end

endmodule
`default_nettype wire

// ===== ptp_pll_clock_servo_core.f =====
sv/pcs_pkg.sv
sv/pcs_muldiv.sv
sv/ptp_pll_clock_servo_core.sv
sv/pcs_checker.sv
dv/ptp_pll_clock_servo_core_tb.sv
